// ===== design/fcas_pkg.sv =====
// Package for the fixed chunk allocator: request, response and queue command types,
// plus the status and kind codes. No dependencies.
package fcas_pkg;

   // Sum of a 10-bit start index and a 10-bit offset
   localparam int ADDR_SUM_W = 11;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_WRITE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_FREE      = 3'd1,
      ST_BAD_FREE     = 3'd2,
      ST_ALREADY_FREE = 3'd3,
      ST_OFFSET       = 3'd4,
      ST_BEYOND       = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } back_op_type;

   typedef struct packed {
      kind_type           kind;
      logic [9:0]         start_index;
      logic [9:0]         offset;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [9:0]         chunk_start;
      logic signed [31:0] read_data;
   } rsp_type;

   // Command handed from the front to the back through the queue
   typedef struct packed {
      back_op_type             op;
      logic [ADDR_SUM_W-1:0]   addr;
      logic signed [31:0]      write_value;
      status_type              status;
      logic [9:0]              chunk_start;
   } cmd_type;

endpackage

// ===== design/fcas_front.sv =====
// Front of the chunk allocator: owns the chunk used bitmap, classifies each request
// and checks its address. Depends on fcas_pkg.
module fcas_front #(
   parameter int CHUNK_WORDS = 128,
   parameter int NUM_CHUNKS  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fcas_pkg::req_type req_item,
   output fcas_pkg::cmd_type cmd
);
   import fcas_pkg::*;

   localparam int STORE_WORDS = CHUNK_WORDS * NUM_CHUNKS;

   logic [NUM_CHUNKS-1:0] used_ff, used_in;
   logic [NUM_CHUNKS-1:0] free_vec, pick, hit;
   logic                  any_free, in_store, hit_used, off_bad, beyond;
   logic [9:0]            alloc_start;
   logic [31:0]           start_w, off_w, sum_w;
   logic [ADDR_SUM_W-1:0] sum;

   assign free_vec = ~used_ff;
   // Isolate the lowest free chunk
   assign pick     = free_vec & (~free_vec + NUM_CHUNKS'(1));
   assign any_free = |free_vec;

   assign start_w = 32'(req_item.start_index);
   assign off_w   = 32'(req_item.offset);
   assign sum     = ADDR_SUM_W'(req_item.start_index) + ADDR_SUM_W'(req_item.offset);
   assign sum_w   = 32'(sum);

   always_comb begin
      alloc_start = '0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
         if (pick[i]) begin
            alloc_start = alloc_start | 10'(i * CHUNK_WORDS);
         end
         hit[i] = (start_w >= 32'(i * CHUNK_WORDS)) && (start_w < 32'((i + 1) * CHUNK_WORDS));
      end
   end

   assign in_store = start_w < 32'(STORE_WORDS);
   assign hit_used = |(hit & used_ff);
   assign off_bad  = off_w >= 32'(CHUNK_WORDS);
   assign beyond   = sum_w >= 32'(STORE_WORDS);

   always_comb begin
      cmd             = '0;
      cmd.op          = OP_NONE;
      cmd.status      = ST_OK;
      cmd.addr        = sum;
      cmd.write_value = req_item.write_value;
      used_in         = used_ff;
      unique case (req_item.kind)
         KIND_ALLOC: begin
            if (any_free) begin
               cmd.chunk_start = alloc_start;
               used_in         = used_ff | pick;
            end else begin
               cmd.status = ST_NO_FREE;
            end
         end
         KIND_FREE: begin
            if (!in_store) begin
               cmd.status = ST_BAD_FREE;
            end else if (!hit_used) begin
               cmd.status = ST_ALREADY_FREE;
            end else begin
               used_in = used_ff & ~hit;
            end
         end
         KIND_READ, KIND_WRITE: begin
            if (off_bad) begin
               cmd.status = ST_OFFSET;
            end else if (beyond) begin
               cmd.status = ST_BEYOND;
            end else begin
               cmd.op = (req_item.kind == KIND_READ) ? OP_READ : OP_WRITE;
            end
         end
         default: begin
            cmd.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (accept) begin
         used_ff <= used_in;
      end
   end

endmodule

// ===== design/fcas_queue.sv =====
// Two-entry command queue between the front and the back of the chunk allocator.
// Depends on fcas_pkg.
module fcas_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fcas_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output fcas_pkg::cmd_type head
);
   import fcas_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign not_empty = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== design/fcas_back.sv =====
// Back of the chunk allocator: holds the word store, carries out reads and writes
// and drives the registered response. Depends on fcas_pkg.
module fcas_back #(
   parameter int CHUNK_WORDS = 128,
   parameter int NUM_CHUNKS  = 8,
   parameter int DATA_WIDTH  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  fcas_pkg::cmd_type cmd,
   output logic              rsp_strobe,
   output fcas_pkg::rsp_type rsp_item
);
   import fcas_pkg::*;

   localparam int STORE_WORDS = CHUNK_WORDS * NUM_CHUNKS;
   // Addresses never reach past the largest start plus offset sum
   localparam int MEM_DEPTH   = (STORE_WORDS < (1 << ADDR_SUM_W)) ? STORE_WORDS
                                                                  : (1 << ADDR_SUM_W);
   localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic [DATA_WIDTH-1:0] store_mem [MEM_DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [MEM_AW-1:0]     mem_addr;
   logic                  strobe_ff;
   logic                  is_read_ff;
   status_type            status_ff;
   logic [9:0]            chunk_start_ff;

   assign mem_addr = cmd.addr[MEM_AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd.op == OP_WRITE) begin
         store_mem[mem_addr] <= DATA_WIDTH'(cmd.write_value);
      end
      rd_ff <= store_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= cmd.status;
      chunk_start_ff <= cmd.chunk_start;
      is_read_ff     <= cmd.op == OP_READ;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_item.status      = status_ff;
   assign rsp_item.chunk_start = chunk_start_ff;
   assign rsp_item.read_data   = is_read_ff ? signed'(32'(rd_ff)) : '0;

endmodule

// ===== design/fixed_chunk_allocator_with_store.sv =====
// Top level of the fixed chunk allocator with its word store.
// Depends on fcas_pkg, fcas_front, fcas_queue and fcas_back.
//
// The block splits a word store into NUM_CHUNKS chunks of CHUNK_WORDS words and
// takes one request per clock: a request is transferred at a rising edge with start
// high and busy low, and exactly one response follows, in request order, once it has
// passed the queue and the response registers, on rsp_item for the single cycle that
// rsp_strobe is high. The receiver cannot stall, so the back end drains the two-entry
// queue every cycle and busy stays low in steady use; it rises only if that queue ever
// holds two commands. The front end updates the chunk bitmap at the transfer edge, so
// an allocate or free is seen by the very next request. Reading a word that was never
// written returns an unspecified value.
module fixed_chunk_allocator_with_store #(
   parameter int CHUNK_WORDS = 128,
   parameter int NUM_CHUNKS  = 8,
   parameter int DATA_WIDTH  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fcas_pkg::req_type req_item,
   output logic              rsp_strobe,
   output fcas_pkg::rsp_type rsp_item
);
   import fcas_pkg::*;

   logic    accept;
   logic    q_not_empty;
   logic    q_full;
   cmd_type front_cmd;
   cmd_type q_head;

   // Hold off new requests only while the queue is full
   assign busy   = q_full;
   assign accept = start && !q_full;

   // Classify the request, update the bitmap, check the address
   fcas_front #(
      .CHUNK_WORDS(CHUNK_WORDS),
      .NUM_CHUNKS (NUM_CHUNKS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_item(req_item),
      .cmd     (front_cmd)
   );

   // Decouple the front from the store access
   fcas_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (q_not_empty),
      .not_empty(q_not_empty),
      .full     (q_full),
      .head     (q_head)
   );

   // Access the store and register the response
   fcas_back #(
      .CHUNK_WORDS(CHUNK_WORDS),
      .NUM_CHUNKS (NUM_CHUNKS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_head),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

endmodule
